// File: rtl/netbios_name_response_parser_assert.svh
// Assertion macros for the name response parser.
// NBNS_ASSERT is masked while reset is held; NBNS_ASSERT_ALWAYS is checked at every edge.
`ifndef NETBIOS_NAME_RESPONSE_PARSER_ASSERT_SVH
`define NETBIOS_NAME_RESPONSE_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define NBNS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NBNS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NBNS_ASSERT(lbl, clk, rst_n, prop, msg)
`define NBNS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/nbns_pkg.sv
package nbns_pkg;

    // Parse position within the response packet
    typedef enum logic [3:0] {
        PH_ID,
        PH_FLAGS,
        PH_QD,
        PH_AN,
        PH_NSAR,
        PH_LEN,
        PH_LABEL,
        PH_TC,
        PH_TTL,
        PH_RDLEN,
        PH_REC,
        PH_DRAIN
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_REC  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ID_MISM  = 3'd1;
    localparam logic [2:0] ST_NOT_RESP = 3'd2;
    localparam logic [2:0] ST_ANCOUNT  = 3'd3;
    localparam logic [2:0] ST_TYPE_CLS = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    // Protocol constants
    localparam logic [31:0] TYPE_CLASS_NB_IN = 32'h0020_0001;
    localparam logic [15:0] ANCOUNT_ONE      = 16'h0001;
    localparam logic [7:0]  ALPHA_BASE       = 8'h41;
    localparam logic [15:0] ADDR_ENTRY_BYTES = 16'd6;
    localparam int          NB_FLAGS_LSB     = 13;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_char;
        logic [31:0] ip_address;
        logic [2:0]  nb_flags;
        logic [13:0] addr_index;
        logic [31:0] ttl;
        logic [15:0] txn_id;
        logic [2:0]  status;
        logic        last;
    } t_result;

    // Up to two results produced by one packet byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic             room;
        logic [RQ_CW-1:0] count;
    } t_rq_stat;

    // Bytes in each fixed-size header field
    function automatic logic [2:0] field_need(input t_phase ph);
        logic [2:0] need;
        case (ph)
            PH_NSAR, PH_TC, PH_TTL: need = 3'd4;
            default:                need = 3'd2;
        endcase
        return need;
    endfunction

endpackage

// File: rtl/nbns_if.sv
// Packet byte channel
interface nbns_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, in_byte, last_byte, input ready);
    modport sink (input valid, in_byte, last_byte, output ready);
endinterface

// Result channel
interface nbns_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [31:0] ip_address;
    logic [2:0]  nb_flags;
    logic [13:0] addr_index;
    logic [31:0] ttl;
    logic [15:0] txn_id;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, kind, name_char, ip_address, nb_flags, addr_index,
                    ttl, txn_id, status, last, input ready);
    modport sink (input valid, kind, name_char, ip_address, nb_flags, addr_index,
                  ttl, txn_id, status, last, output ready);
endinterface

// Configuration write channel
interface nbns_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] expected_txn_id;

    modport source (output valid, expected_txn_id, input ready);
    modport sink (input valid, expected_txn_id, output ready);
endinterface

// File: rtl/nbns_parse.sv
module nbns_parse
    import nbns_pkg::*;
#(
    parameter int ENC_NAME_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbns_in_if.sink     i_in,
    input  logic [15:0] i_exp_txn_id,
    input  t_rq_stat    i_rq_stat,
    output t_push       o_push
);

    localparam int NPW = $clog2(ENC_NAME_LEN + 2);

    logic           r_vld;
    logic [7:0]     r_byte;
    logic           r_last;

    t_phase         r_phase, n_phase;
    logic [2:0]     r_cnt, n_cnt;
    logic [31:0]    r_shift, n_shift;
    logic [7:0]     r_rem, n_rem;
    logic           r_first, n_first;
    logic [7:0]     r_hi, n_hi;
    logic [15:0]    r_dll, n_dll;
    logic [2:0]     r_flags, n_flags;
    logic [13:0]    r_count, n_count;
    logic [31:0]    r_ttl, n_ttl;
    logic [15:0]    r_txn, n_txn;
    logic [NPW-1:0] r_pos, n_pos;

    logic           advance;
    logic [31:0]    shift_nx;
    logic [2:0]     cnt_nx;
    logic [7:0]     hi_d, lo_d;
    logic           p_vld, f_vld;
    t_result        p_res;
    logic [2:0]     f_st;
    t_result        f_res;

    // Take a byte when the stage is empty or moves on this cycle
    assign advance    = r_vld && i_rq_stat.room;
    assign i_in.ready = !r_vld || i_rq_stat.room;

    assign shift_nx = {r_shift[23:0], r_byte};
    assign cnt_nx   = r_cnt + 3'd1;
    assign hi_d     = r_hi - ALPHA_BASE;
    assign lo_d     = r_byte - ALPHA_BASE;

    // Field update for the held byte
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_first = r_first;
        n_hi    = r_hi;
        n_dll   = r_dll;
        n_flags = r_flags;
        n_count = r_count;
        n_ttl   = r_ttl;
        n_txn   = r_txn;
        n_pos   = r_pos;
        p_vld   = 1'b0;
        p_res   = '0;
        f_vld   = 1'b0;
        f_st    = ST_OK;
        case (r_phase)
            PH_ID, PH_FLAGS, PH_QD, PH_AN, PH_NSAR, PH_TC, PH_TTL, PH_RDLEN: begin
                n_shift = shift_nx;
                n_cnt   = cnt_nx;
                if (cnt_nx >= field_need(r_phase)) begin
                    n_shift = '0;
                    n_cnt   = '0;
                    case (r_phase)
                        PH_ID: begin
                            n_txn = shift_nx[15:0];
                            if (shift_nx[15:0] != i_exp_txn_id) begin
                                f_vld = 1'b1;
                                f_st  = ST_ID_MISM;
                            end else begin
                                n_phase = PH_FLAGS;
                            end
                        end
                        PH_FLAGS: begin
                            if (!shift_nx[15]) begin
                                f_vld = 1'b1;
                                f_st  = ST_NOT_RESP;
                            end else begin
                                n_phase = PH_QD;
                            end
                        end
                        PH_QD: n_phase = PH_AN;
                        PH_AN: begin
                            if (shift_nx[15:0] != ANCOUNT_ONE) begin
                                f_vld = 1'b1;
                                f_st  = ST_ANCOUNT;
                            end else begin
                                n_phase = PH_NSAR;
                            end
                        end
                        PH_NSAR: n_phase = PH_LEN;
                        PH_TC: begin
                            if (shift_nx != TYPE_CLASS_NB_IN) begin
                                f_vld = 1'b1;
                                f_st  = ST_TYPE_CLS;
                            end else begin
                                n_phase = PH_TTL;
                            end
                        end
                        PH_TTL: begin
                            n_ttl   = shift_nx;
                            n_phase = PH_RDLEN;
                        end
                        default: begin
                            n_dll = shift_nx[15:0];
                            if (shift_nx[15:0] < ADDR_ENTRY_BYTES) begin
                                f_vld = 1'b1;
                                f_st  = ST_OK;
                            end else begin
                                n_phase = PH_REC;
                            end
                        end
                    endcase
                end
            end
            PH_LEN: begin
                if (r_byte == 8'd0) begin
                    n_first = 1'b0;
                    n_phase = PH_TC;
                end else begin
                    n_rem   = r_byte;
                    n_pos   = '0;
                    n_phase = PH_LABEL;
                end
            end
            PH_LABEL: begin
                // Decode byte pairs of the first label only
                if (r_first) begin
                    n_pos = r_pos + NPW'(1);
                    if (!r_pos[0]) begin
                        if (r_pos >= NPW'(ENC_NAME_LEN) || r_byte == 8'd0) begin
                            n_first = 1'b0;
                        end else begin
                            n_hi = r_byte;
                        end
                    end else if (r_byte == 8'd0) begin
                        n_first = 1'b0;
                    end else begin
                        p_vld           = 1'b1;
                        p_res.kind      = KIND_CHAR;
                        p_res.name_char = {hi_d[3:0], 4'h0} | lo_d;
                    end
                end
                n_rem = r_rem - 8'd1;
                if (r_rem == 8'd1) begin
                    n_first = 1'b0;
                    n_phase = PH_LEN;
                end
            end
            PH_REC: begin
                n_shift = shift_nx;
                n_cnt   = cnt_nx;
                if (cnt_nx == 3'd2) begin
                    n_flags = shift_nx[NB_FLAGS_LSB +: 3];
                    n_shift = '0;
                end else if (cnt_nx >= 3'd6) begin
                    p_vld            = 1'b1;
                    p_res.kind       = KIND_REC;
                    p_res.ip_address = shift_nx;
                    p_res.nb_flags   = r_flags;
                    p_res.addr_index = r_count;
                    n_count          = r_count + 14'd1;
                    n_shift          = '0;
                    n_cnt            = '0;
                    n_dll            = r_dll - ADDR_ENTRY_BYTES;
                    if (n_dll < ADDR_ENTRY_BYTES) begin
                        f_vld = 1'b1;
                        f_st  = ST_OK;
                    end
                end
            end
            default: n_phase = PH_DRAIN;
        endcase
        if (f_vld) begin
            n_phase = PH_DRAIN;
        end
        // Flag a packet that ends before its status
        if (r_last && !f_vld && n_phase != PH_DRAIN) begin
            f_vld = 1'b1;
            f_st  = ST_TRUNC;
        end
        p_res.txn_id = n_txn;
    end

    // Build the status result
    always_comb begin
        f_res            = '0;
        f_res.kind       = KIND_STAT;
        f_res.addr_index = n_count;
        f_res.ttl        = n_ttl;
        f_res.txn_id     = n_txn;
        f_res.status     = f_st;
        f_res.last       = 1'b1;
    end

    // Pack results into push slots
    always_comb begin
        o_push      = '0;
        o_push.res0 = p_vld ? p_res : f_res;
        o_push.res1 = f_res;
        if (advance) begin
            o_push.cnt = {1'b0, p_vld} + {1'b0, f_vld};
        end
    end

    // Hold the input byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.last_byte;
        end
    end

    // Advance parse state; restart after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_last)) begin
            r_phase <= PH_ID;
            r_cnt   <= '0;
            r_shift <= '0;
            r_rem   <= '0;
            r_first <= 1'b1;
            r_hi    <= '0;
            r_dll   <= '0;
            r_flags <= '0;
            r_count <= '0;
            r_ttl   <= '0;
            r_txn   <= '0;
            r_pos   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_rem   <= n_rem;
            r_first <= n_first;
            r_hi    <= n_hi;
            r_dll   <= n_dll;
            r_flags <= n_flags;
            r_count <= n_count;
            r_ttl   <= n_ttl;
            r_txn   <= n_txn;
            r_pos   <= n_pos;
        end
    end

endmodule

// File: rtl/nbns_rqueue.sv
module nbns_rqueue
    import nbns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output t_rq_stat  o_stat,
    nbns_out_if.source o_out
);

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp, n_wp;
    logic [RQ_AW-1:0] r_rp, n_rp;
    logic [RQ_CW-1:0] r_count, n_count;
    logic             pop;
    t_result          head;

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_mem[r_rp];

    // Drive the result channel from the head entry
    assign o_out.valid      = (r_count != '0);
    assign o_out.kind       = head.kind;
    assign o_out.name_char  = head.name_char;
    assign o_out.ip_address = head.ip_address;
    assign o_out.nb_flags   = head.nb_flags;
    assign o_out.addr_index = head.addr_index;
    assign o_out.ttl        = head.ttl;
    assign o_out.txn_id     = head.txn_id;
    assign o_out.status     = head.status;
    assign o_out.last       = head.last;

    assign o_stat.count = r_count;
    assign o_stat.room  = (r_count <= RQ_CW'(RQ_DEPTH - 2));

    // Pointer and occupancy update
    always_comb begin
        n_wp    = r_wp + RQ_AW'(i_push.cnt);
        n_rp    = r_rp + RQ_AW'(pop);
        n_count = r_count + RQ_CW'(i_push.cnt) - RQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Write one or two entries
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + RQ_AW'(1)] <= i_push.res1;
        end
    end

endmodule

// File: rtl/netbios_name_response_parser.sv
// Name query response parser. Packet bytes enter on i_in, one per cycle, with
// last_byte on the final byte; results leave on o_out: a decoded character for each
// byte pair of the first name label, a record for each six-byte address entry, and
// a final status (last = 1) that carries the TTL, the record count and the outcome.
// A byte is taken every cycle while the four-entry result queue has two free
// entries; a byte yields at most two results, which drain one per cycle, so
// input stalls only when the sink takes fewer results than the packet produces.
// A byte's first result passes through the input register and then the queue.
// The expected transaction id must be written through i_cfg between packets; the block does not enforce this.
`include "netbios_name_response_parser_assert.svh"

module netbios_name_response_parser
    import nbns_pkg::*;
#(
    parameter int ENC_NAME_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nbns_cfg_if.sink   i_cfg,
    nbns_in_if.sink    i_in,
    nbns_out_if.source o_out
);

    logic [15:0] r_exp_txn_id;
    t_push       push;
    t_rq_stat    rq_stat;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_txn_id <= '0;
        end else if (i_cfg.valid) begin
            r_exp_txn_id <= i_cfg.expected_txn_id;
        end
    end

    nbns_parse #(
        .ENC_NAME_LEN(ENC_NAME_LEN)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_exp_txn_id(r_exp_txn_id),
        .i_rq_stat   (rq_stat),
        .o_push      (push)
    );

    nbns_rqueue u_rqueue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_stat (rq_stat),
        .o_out  (o_out)
    );

    `NBNS_ASSERT(a_rq_no_overflow, i_clk, i_rst_n, rq_stat.count <= RQ_CW'(RQ_DEPTH), "result queue overflow")
    `NBNS_ASSERT(a_second_is_status, i_clk, i_rst_n, push.cnt == 2'd2 |-> push.res1.kind == KIND_STAT && push.res1.last, "second result of a byte is not a status")
    `NBNS_ASSERT(a_last_is_status, i_clk, i_rst_n, o_out.valid && o_out.last |-> o_out.kind == KIND_STAT, "last flag on a non-status result")
    `NBNS_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !$past(i_rst_n) |-> rq_stat.count == '0 && !o_out.valid, "result queue not empty after reset")

endmodule
